/* rtl/gat_pkg.sv */
// Shared types and constants for the gimbal aim command tracker.
`default_nettype none
package gat_pkg;

   localparam int FRAME_LEN = 7;
   localparam int KEEP_LEN  = FRAME_LEN - 1;

   localparam logic [7:0] FRAME_HEAD0 = 8'hAA;
   localparam logic [7:0] FRAME_HEAD1 = 8'hAB;
   localparam logic [7:0] FRAME_TAIL  = 8'hAC;

   localparam logic [2:0] CSR_YAW_GAIN   = 3'd0;
   localparam logic [2:0] CSR_YAW_OFFSET = 3'd1;
   localparam logic [2:0] CSR_YAW_SAT    = 3'd2;
   localparam logic [2:0] CSR_PITCH_INC  = 3'd3;
   localparam logic [2:0] CSR_PITCH_UP   = 3'd4;
   localparam logic [2:0] CSR_PITCH_LOW  = 3'd5;
   localparam logic [2:0] CSR_YAW_UP     = 3'd6;
   localparam logic [2:0] CSR_YAW_LOW    = 3'd7;

   localparam logic        OP_BYTE = 1'b0;
   localparam logic        OP_TICK = 1'b1;

   // Last six received bytes, index 0 the oldest.
   typedef logic [KEEP_LEN-1:0][7:0] window_type;

   typedef struct packed {
      logic               yaw_load;
      logic signed [31:0] yaw_rate;
      logic               pitch_load;
      logic signed [31:0] pitch_rate;
      logic               mode_load;
      logic               home;
   } decode_type;

endpackage
`default_nettype wire

/* rtl/gat_decode.sv */
// Frame detection and command mapping for the gimbal aim command tracker.
`default_nettype none
module gat_decode (
   input  wire gat_pkg::window_type  window,
   input  wire logic [7:0]           new_byte,
   input  wire logic                 byte_valid,
   input  wire logic signed [31:0]   yaw_gain,
   input  wire logic signed [31:0]   yaw_offset,
   input  wire logic [30:0]          yaw_saturation,
   input  wire logic [30:0]          pitch_increment,
   output gat_pkg::decode_type       decode
);

   localparam logic signed [41:0] SAT_MAX = 42'sd2147483647;
   localparam logic signed [41:0] SAT_MIN = -42'sd2147483648;

   logic               frame_hit;
   logic signed [8:0]  pitch_raw;
   logic signed [8:0]  yaw_raw;
   logic signed [40:0] yaw_prod;
   logic signed [41:0] yaw_lin;
   logic signed [31:0] yaw_lin_sat;
   logic signed [31:0] yaw_sat_pos;
   logic signed [31:0] pitch_inc_pos;

   // Frame bytes before the shift: byte k is window[k], byte 6 the new byte.
   assign frame_hit = byte_valid && (window[0] == gat_pkg::FRAME_HEAD0)
                      && (window[1] == gat_pkg::FRAME_HEAD1)
                      && (new_byte == gat_pkg::FRAME_TAIL);

   assign pitch_raw = $signed({1'b0, window[3]}) - 9'sd100;
   assign yaw_raw   = $signed({1'b0, window[6 - 1]}) - 9'sd100;

   assign yaw_prod = 41'(yaw_gain) * 41'(yaw_raw);

   always_comb begin
      if (yaw_raw > 9'sd0) begin
         yaw_lin = 42'(yaw_prod) + 42'(yaw_offset);
      end else begin
         yaw_lin = 42'(yaw_prod) - 42'(yaw_offset);
      end
      if (yaw_lin > SAT_MAX) begin
         yaw_lin_sat = 32'sh7FFFFFFF;
      end else if (yaw_lin < SAT_MIN) begin
         yaw_lin_sat = 32'sh80000000;
      end else begin
         yaw_lin_sat = yaw_lin[31:0];
      end
   end

   assign yaw_sat_pos   = $signed({1'b0, yaw_saturation});
   assign pitch_inc_pos = $signed({1'b0, pitch_increment});

   always_comb begin
      decode.yaw_load   = 1'b0;
      decode.yaw_rate   = '0;
      decode.pitch_load = 1'b0;
      decode.pitch_rate = '0;
      decode.mode_load  = 1'b0;
      decode.home       = 1'b0;
      if (frame_hit) begin
         if (yaw_raw >= 9'sd90 && yaw_raw <= 9'sd100) begin
            decode.yaw_load = 1'b1;
            decode.yaw_rate = yaw_sat_pos;
         end else if (yaw_raw <= -9'sd90) begin
            decode.yaw_load = 1'b1;
            decode.yaw_rate = -yaw_sat_pos;
         end else if (yaw_raw >= -9'sd10 && yaw_raw <= 9'sd10) begin
            decode.yaw_load = 1'b1;
            decode.yaw_rate = '0;
         end else if (yaw_raw < 9'sd90) begin
            decode.yaw_load = 1'b1;
            decode.yaw_rate = yaw_lin_sat;
         end

         if (pitch_raw > 9'sd10 && pitch_raw < 9'sd100) begin
            decode.pitch_load = 1'b1;
            decode.pitch_rate = pitch_inc_pos;
            decode.mode_load  = 1'b1;
         end else if (pitch_raw < -9'sd10) begin
            decode.pitch_load = 1'b1;
            decode.pitch_rate = -pitch_inc_pos;
            decode.mode_load  = 1'b1;
         end else if (pitch_raw <= 9'sd10 && pitch_raw >= -9'sd10) begin
            decode.pitch_load = 1'b1;
            decode.mode_load  = 1'b1;
         end else if (pitch_raw == 9'sd150) begin
            // return-home keeps the pitch rate
            decode.mode_load = 1'b1;
            decode.home      = 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

/* rtl/gimbal_aim_command_tracker.sv */
// Top level of the gimbal aim command tracker.
`default_nettype none
// Takes one item per cycle: a link byte (operation 0) or a control tick
// (operation 1). Bytes shift through a six-byte window; a frame that starts
// with 0xAA 0xAB and ends with 0xAC is decoded on the byte that completes it,
// setting the yaw rate, pitch rate and mode in the same cycle, so a tick may
// follow directly. Each tick gives one result, in the cycle after acceptance,
// from a single output register; bytes give none. The only pacing is that
// register: req_stall rises while a result waits and rsp_stall is high.
// Configuration registers are written through csr_write/csr_index/csr_data.
module gimbal_aim_command_tracker (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_operation,
   input  wire logic [7:0]         req_link_byte,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_yaw_target,
   output logic signed [31:0]      rsp_pitch_target,
   output logic                    rsp_tracking,
   input  wire logic               csr_write,
   input  wire logic [2:0]         csr_index,
   input  wire logic [31:0]        csr_data
);

   logic signed [31:0] yaw_gain_ff;
   logic signed [31:0] yaw_offset_ff;
   logic [30:0]        yaw_saturation_ff;
   logic [30:0]        pitch_increment_ff;
   logic signed [31:0] pitch_upper_ff;
   logic signed [31:0] pitch_lower_ff;
   logic signed [31:0] yaw_upper_ff;
   logic signed [31:0] yaw_lower_ff;

   gat_pkg::window_type window_ff;
   logic signed [31:0]  yaw_rate_ff;
   logic signed [31:0]  pitch_rate_ff;
   logic                home_mode_ff;
   logic signed [31:0]  yaw_angle_ff;
   logic signed [31:0]  pitch_angle_ff;
   logic signed [31:0]  yaw_angle_in;
   logic signed [31:0]  pitch_angle_in;

   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                rsp_tracking_ff;

   logic                accept;
   logic                byte_accept;
   logic                tick_accept;
   gat_pkg::decode_type decode;

   function automatic logic signed [31:0] step_clamp(
      input logic signed [31:0] angle,
      input logic signed [31:0] rate,
      input logic signed [31:0] upper,
      input logic signed [31:0] lower
   );
      logic signed [32:0] sum;
      sum = 33'(angle) + 33'(rate);
      if (sum > 33'(upper)) begin
         return upper;
      end else if (sum < 33'(lower)) begin
         return lower;
      end
      return sum[31:0];
   endfunction

   assign req_stall   = rsp_valid_ff && rsp_stall;
   assign accept      = req_valid && !req_stall;
   assign byte_accept = accept && (req_operation == gat_pkg::OP_BYTE);
   assign tick_accept = accept && (req_operation == gat_pkg::OP_TICK);

   gat_decode u_decode (
      .window          (window_ff),
      .new_byte        (req_link_byte),
      .byte_valid      (byte_accept),
      .yaw_gain        (yaw_gain_ff),
      .yaw_offset      (yaw_offset_ff),
      .yaw_saturation  (yaw_saturation_ff),
      .pitch_increment (pitch_increment_ff),
      .decode          (decode)
   );

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         yaw_gain_ff        <= '0;
         yaw_offset_ff      <= -32'sd464;
         yaw_saturation_ff  <= 31'd3495;
         pitch_increment_ff <= 31'd262;
         pitch_upper_ff     <= 32'sh7FFFFFFF;
         pitch_lower_ff     <= 32'sh80000000;
         yaw_upper_ff       <= 32'sh7FFFFFFF;
         yaw_lower_ff       <= 32'sh80000000;
      end else if (csr_write) begin
         unique case (csr_index)
            gat_pkg::CSR_YAW_GAIN:   yaw_gain_ff        <= csr_data;
            gat_pkg::CSR_YAW_OFFSET: yaw_offset_ff      <= csr_data;
            gat_pkg::CSR_YAW_SAT:    yaw_saturation_ff  <= csr_data[30:0];
            gat_pkg::CSR_PITCH_INC:  pitch_increment_ff <= csr_data[30:0];
            gat_pkg::CSR_PITCH_UP:   pitch_upper_ff     <= csr_data;
            gat_pkg::CSR_PITCH_LOW:  pitch_lower_ff     <= csr_data;
            gat_pkg::CSR_YAW_UP:     yaw_upper_ff       <= csr_data;
            gat_pkg::CSR_YAW_LOW:    yaw_lower_ff       <= csr_data;
            default: ;
         endcase
      end
   end

   // Byte window, rates and mode.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff     <= '0;
         yaw_rate_ff   <= '0;
         pitch_rate_ff <= '0;
         home_mode_ff  <= 1'b1;
      end else if (byte_accept) begin
         window_ff <= {req_link_byte, window_ff[gat_pkg::KEEP_LEN-1:1]};
         if (decode.yaw_load) begin
            yaw_rate_ff <= decode.yaw_rate;
         end
         if (decode.pitch_load) begin
            pitch_rate_ff <= decode.pitch_rate;
         end
         if (decode.mode_load) begin
            home_mode_ff <= decode.home;
         end
      end
   end

   // Advance targets only in tracking mode; hold them otherwise.
   always_comb begin
      yaw_angle_in   = yaw_angle_ff;
      pitch_angle_in = pitch_angle_ff;
      if (tick_accept && !home_mode_ff) begin
         yaw_angle_in   = step_clamp(yaw_angle_ff, yaw_rate_ff, yaw_upper_ff, yaw_lower_ff);
         pitch_angle_in = step_clamp(pitch_angle_ff, pitch_rate_ff,
                                     pitch_upper_ff, pitch_lower_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         yaw_angle_ff   <= '0;
         pitch_angle_ff <= '0;
      end else begin
         yaw_angle_ff   <= yaw_angle_in;
         pitch_angle_ff <= pitch_angle_in;
      end
   end

   assign rsp_valid_in = tick_accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the mode of each accepted tick for its result.
   always_ff @(posedge clock) begin
      if (tick_accept) begin
         rsp_tracking_ff <= !home_mode_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_yaw_target   = yaw_angle_ff;
   assign rsp_pitch_target = pitch_angle_ff;
   assign rsp_tracking     = rsp_tracking_ff;

`ifndef ASSERT_OFF
   a_home_holds: assert property (@(posedge clock) disable iff (reset)
      tick_accept && home_mode_ff |=> $stable(yaw_angle_ff) && $stable(pitch_angle_ff))
      else $error("targets moved on a tick in return-home mode");

   a_byte_no_result: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff && !tick_accept |=> !rsp_valid_ff)
      else $error("result appeared without a tick");

   a_targets_held_while_waiting: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> $stable(yaw_angle_ff) && $stable(pitch_angle_ff))
      else $error("targets changed while a result waits");

   a_yaw_in_limits: assert property (@(posedge clock) disable iff (reset)
      tick_accept && !home_mode_ff && (yaw_lower_ff <= yaw_upper_ff)
      |=> (yaw_angle_ff <= $past(yaw_upper_ff)) && (yaw_angle_ff >= $past(yaw_lower_ff)))
      else $error("yaw target outside its limits");
`endif

endmodule
`default_nettype wire
